// File: rtl/fbe_pkg.sv
// Package: shared types and constants of the filter bank band energy block.
package fbe_pkg;

  localparam int DEF_MAX_BANDS   = 32;
  localparam int DEF_MAX_BINS    = 512;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DEF_SAMPLE_BITS = 32;

  localparam int FRAC_BITS  = 14;
  localparam int ACC_BITS   = 57;
  localparam int VALUE_BITS = 48;
  localparam int ROOT_BITS  = 16;

  typedef enum logic [1:0] {
    ACT_WEIGHT = 2'd0,
    ACT_BOUNDS = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [1:0] CFG_NUM_BINS = 2'd0;
  localparam logic [1:0] CFG_BANDS    = 2'd1;
  localparam logic [1:0] CFG_COMPRESS = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  band_addr;
    logic [8:0]  bin_index;
    logic [15:0] weight;
    logic [8:0]  range_first;
    logic [8:0]  range_last;
    logic [31:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  band;
    logic [47:0] band_value;
    logic        last;
  } out_word_t;

  // Sequencer state
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_START,
    ST_ROOT,
    ST_SEND
  } state_t;

  // Command given to every cell of the row
  typedef struct packed {
    logic valid;
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// File: rtl/fbe_ram.sv
// Generic single-port-write, registered-read RAM.
module fbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/fbe_cell.sv
// One band cell: bounds, multiply-accumulate and shift-out of the band sum.
module fbe_cell
  import fbe_pkg::*;
#(
  parameter int BIN_W       = 9,
  parameter int WEIGHT_BITS = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   bnd_we,
  input  logic [8:0]             first_in,
  input  logic [8:0]             last_in,
  input  cell_ctl_t              ctl,
  input  logic [BIN_W-1:0]       bin,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic                   en,
  input  logic [ACC_BITS-1:0]    acc_in,
  output logic [ACC_BITS-1:0]    acc_out
);
  localparam int PROD_W = WEIGHT_BITS + SAMPLE_BITS;
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  logic [8:0]          first_r, last_r;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     prod_ext;
  logic [ACC_BITS:0]   sum;
  logic                hit;

  always_ff @(posedge clk) begin
    if (bnd_we) begin
      first_r <= first_in;
      last_r  <= last_in;
    end
  end

  always_comb begin
    prod     = PROD_W'(sample) * PROD_W'(weight);
    prod_ext = {1'b0, prod};
    hit      = en && ({1'b0, bin} >= (BIN_W + 1)'(first_r))
                  && ({1'b0, bin} <= (BIN_W + 1)'(last_r));
    sum      = {1'b0, acc_r} + (ACC_BITS + 1)'(prod_ext);
    acc_nxt  = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = acc_in;
    end else if (ctl.valid && hit) begin
      acc_nxt = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_out = acc_r;
endmodule

// File: rtl/fbe_cbrt.sv
// Bit-serial floor cube root, most significant result bit first.
module fbe_cbrt
  import fbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  done,
  output logic [ROOT_BITS-1:0]  root
);
  logic [VALUE_BITS-1:0] v_r;
  logic [ROOT_BITS-1:0]  r_r, cand;
  logic [3:0]            bit_r;
  logic                  busy_r, done_r;
  logic [2*ROOT_BITS-1:0] sq_r;
  logic                   phase_r;
  logic [3*ROOT_BITS-1:0] cube;

  // Each result bit takes two steps: square, then cube and compare.
  always_comb begin
    cand = r_r | (ROOT_BITS'(1) << bit_r);
    cube = (3*ROOT_BITS)'(sq_r) * (3*ROOT_BITS)'(cand);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r     <= value;
        r_r     <= '0;
        bit_r   <= 4'(ROOT_BITS - 1);
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
      end else if (busy_r) begin
        if (!phase_r) begin
          sq_r    <= (2*ROOT_BITS)'(cand) * (2*ROOT_BITS)'(cand);
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (cube <= v_r) r_r <= cand;
          if (bit_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            bit_r <= bit_r - 4'd1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r;
endmodule

// File: rtl/filter_bank_band_energy.sv
// Top level: filter bank band energy projection over a chain of band cells.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries load words
// (weight writes, band bound writes) and spectrum sample words. One output
// channel (out_valid/out_ready/out_data) carries one word per band in use
// once the last bin in use of a frame has arrived.
// Throughput: load and ignored words go in one per cycle while idle; a sample word
// holds off the input while the weight memory is read, then the cell row adds the
// product, then the sequencer returns to idle. Each band has its own weight memory.
// Frame end: after the last bin is accepted and ST_RUN, ST_DRAIN (with compression
// also ST_START, ST_ROOT), ST_SEND loads the first band word. The chain shifts
// the sums toward band 0, one band per word sent; with the bit-serial cube root each
// word waits for its root. Accumulators clear when the last band word is accepted.
// Reset: accumulators and control clear; weights and bounds stay undefined
// until written. A stalled receiver holds the output word; no input is taken
// until every band word of the frame has been accepted. The user must write
// configuration (cfg_we/cfg_index/cfg_data) only while idle; it is not checked.
module filter_bank_band_energy
  import fbe_pkg::*;
#(
  parameter int MAX_BANDS   = DEF_MAX_BANDS,
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int BND_W = $clog2(MAX_BANDS + 1);

  // Configuration
  logic [9:0] num_bins_r;
  logic [5:0] bands_r;
  logic       compress_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= 10'd256;
      bands_r    <= 6'd23;
      compress_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_BINS: num_bins_r <= cfg_data;
        CFG_BANDS:    bands_r    <= cfg_data[5:0];
        CFG_COMPRESS: compress_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective limits
  logic [12:0]      eff_bins;
  logic [BND_W-1:0] eff_bands;
  always_comb begin
    if (num_bins_r == '0) eff_bins = 13'd1;
    else if (13'(num_bins_r) > 13'(MAX_BINS)) eff_bins = 13'(MAX_BINS);
    else eff_bins = 13'(num_bins_r);
    if (bands_r == '0) eff_bands = BND_W'(1);
    else if (7'(bands_r) > 7'(MAX_BANDS)) eff_bands = BND_W'(MAX_BANDS);
    else eff_bands = BND_W'(bands_r);
  end

  // Sequencer
  state_t state_r, state_nxt;
  logic [BIN_W-1:0]       bin_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   last_bin_r;
  logic [BND_W-1:0]       cnt_r;
  out_word_t              out_r;
  logic                   out_valid_r;
  cell_ctl_t              ctl;
  logic                   acc_sample, in_bin_ok;
  logic                   cbrt_start, cbrt_done;
  logic [ROOT_BITS-1:0]   root;
  logic [ACC_BITS-1:0]    acc_chain [MAX_BANDS+1];
  logic [ACC_BITS-FRAC_BITS-1:0] head_sh;
  logic [VALUE_BITS-1:0]  head_val;
  logic                   load_out;

  assign in_ready   = (state_r == ST_IDLE);
  assign acc_sample = in_valid && in_ready && (in_data.action == ACT_SAMPLE);
  assign in_bin_ok  = (13'(in_data.bin_index) < eff_bins)
                      && (13'(in_data.bin_index) < 13'(MAX_BINS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc_sample && in_bin_ok) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = last_bin_r ? (compress_r ? ST_START : ST_SEND) : ST_IDLE;
      ST_START: state_nxt = ST_ROOT;
      ST_ROOT:  if (cbrt_done) state_nxt = ST_SEND;
      ST_SEND: begin
        if (!out_valid_r || out_ready) begin
          if (out_valid_r && out_r.last) state_nxt = ST_IDLE;
          else if (!out_valid_r) state_nxt = ST_SEND;
          else state_nxt = compress_r ? ST_ROOT : ST_SEND;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Head value of band 0 in the chain; a 57-bit sum shifted by 14 always fits 48 bits
  assign head_sh  = acc_chain[0][ACC_BITS-1:FRAC_BITS];
  assign head_val = VALUE_BITS'(head_sh);

  always_comb begin
    ctl        = '0;
    cbrt_start = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_DRAIN: begin
        ctl.valid = 1'b1;
      end
      // band 0 sum now holds the last bin, start its root
      ST_START: begin
        cbrt_start = 1'b1;
      end
      ST_SEND: begin
        load_out  = !out_valid_r;
        ctl.shift = !out_valid_r;
        if (out_valid_r && out_ready) begin
          ctl.clear  = out_r.last;
          cbrt_start = compress_r && !out_r.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DRAIN) cnt_r <= '0;
      if (load_out) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_r + BND_W'(1);
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_sample) begin
      bin_r      <= in_data.bin_index[BIN_W-1:0];
      sample_r   <= in_data.sample[SAMPLE_BITS-1:0];
      last_bin_r <= (13'(in_data.bin_index) == eff_bins - 13'd1);
    end
    if (load_out) begin
      out_r.band       <= 5'(cnt_r);
      out_r.band_value <= compress_r ? VALUE_BITS'(root) : head_val;
      out_r.last       <= (cnt_r + BND_W'(1) == eff_bands);
    end
  end

  fbe_cbrt u_cbrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cbrt_start),
    .value (head_val),
    .done  (cbrt_done),
    .root  (root)
  );

  // Cell row: band b's sum shifts to band b-1 at each sent word
  assign acc_chain[MAX_BANDS] = '0;
  for (genvar b = 0; b < MAX_BANDS; b++) begin : g_band
    logic [WEIGHT_BITS-1:0] w_rd;
    logic                   we;
    logic                   bnd_we;
    logic                   en;
    assign we = in_valid && in_ready && (in_data.action == ACT_WEIGHT)
                && (32'(in_data.band_addr) == b)
                && (13'(in_data.bin_index) < 13'(MAX_BINS));
    assign bnd_we = in_valid && in_ready && (in_data.action == ACT_BOUNDS)
                    && (32'(in_data.band_addr) == b);
    assign en = (b < 32'(eff_bands));

    fbe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_BINS)) u_wram (
      .clk   (clk),
      .we    (we),
      .waddr (in_data.bin_index[BIN_W-1:0]),
      .wdata (in_data.weight[WEIGHT_BITS-1:0]),
      .raddr (acc_sample ? in_data.bin_index[BIN_W-1:0] : bin_r),
      .rdata (w_rd)
    );

    fbe_cell #(.BIN_W(BIN_W), .WEIGHT_BITS(WEIGHT_BITS),
               .SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bnd_we   (bnd_we),
      .first_in (in_data.range_first),
      .last_in  (in_data.range_last),
      .ctl      (ctl),
      .bin      (bin_r),
      .sample   (sample_r),
      .weight   (w_rd),
      .en       (en),
      .acc_in   (acc_chain[b+1]),
      .acc_out  (acc_chain[b])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_no_in_while_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during band output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> state_r == ST_IDLE)
    else $error("frame did not end after last band");
endmodule

// File: bench/tb_filter_bank_band_energy.sv
// Testbench of the filter bank band energy block: directed and random frames, scoreboard.
`timescale 1ns / 1ps

module tb_filter_bank_band_energy;
  import fbe_pkg::*;

  localparam int NBANDS   = 32;
  localparam int NBINS    = 512;
  localparam int WDOG_MAX = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  filter_bank_band_energy i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block state: weights, bounds, sums, registers.
  logic [15:0] wt_mem [NBANDS][NBINS];
  logic [8:0]  lo_bin [NBANDS];
  logic [8:0]  hi_bin [NBANDS];
  logic [56:0] band_sum [NBANDS];
  logic [9:0]  bins_reg;
  logic [5:0]  bands_reg;
  logic        cbrt_on;

  out_word_t   band_q [$];
  int          err_cnt;
  int          word_cnt;
  int          frame_cnt;
  int          wdog;
  int          snd_idle_pct;
  int          rcv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [47:0] cube_root(input logic [47:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c * c <= {16'd0, v}) r = c;
    end
    return r[47:0];
  endfunction

  function automatic int eff_bins();
    if (bins_reg == 0) return 1;
    if (bins_reg > NBINS) return NBINS;
    return bins_reg;
  endfunction

  function automatic int eff_bands();
    if (bands_reg == 0) return 1;
    if (bands_reg > NBANDS) return NBANDS;
    return bands_reg;
  endfunction

  // Update the shadow state for one word and queue the band energies it releases.
  task automatic predict_bands(input in_word_t w);
    int          nb;
    int          nbd;
    logic [63:0] p;
    logic [63:0] a;
    logic [47:0] v;
    out_word_t   o;
    case (action_t'(w.action))
      ACT_WEIGHT: begin
        wt_mem[w.band_addr][w.bin_index] = w.weight;
      end
      ACT_BOUNDS: begin
        lo_bin[w.band_addr] = w.range_first;
        hi_bin[w.band_addr] = w.range_last;
      end
      ACT_SAMPLE: begin
        nb = eff_bins();
        if (w.bin_index < nb) begin
          nbd = eff_bands();
          for (int b = 0; b < nbd; b++) begin
            if (w.bin_index >= lo_bin[b] && w.bin_index <= hi_bin[b]) begin
              p = 64'(w.sample) * 64'(wt_mem[b][w.bin_index]);
              a = 64'(band_sum[b]) + p;
              band_sum[b] = (a > 64'h01FF_FFFF_FFFF_FFFF) ? '1 : a[56:0];
            end
          end
          if (w.bin_index == nb - 1) begin
            for (int b = 0; b < nbd; b++) begin
              a = 64'(band_sum[b]) >> FRAC_BITS;
              v = (a > 64'h0000_FFFF_FFFF_FFFF) ? '1 : a[47:0];
              o.band = b[4:0];
              o.band_value = cbrt_on ? cube_root(v) : v;
              o.last = (b == nbd - 1);
              band_q.push_back(o);
              band_sum[b] = '0;
            end
            frame_cnt++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // One word on the input channel; valid stays up through the handshake and
  // drops only when the sender idles or stops.
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_bands(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (band_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_NUM_BINS: bins_reg = val;
      CFG_BANDS:    bands_reg = val[5:0];
      CFG_COMPRESS: cbrt_on = val[0];
      default: ;
    endcase
  endtask

  function automatic in_word_t mk_word(input action_t act, input int band, input int bin,
                                       input int wt, input int lo, input int hi,
                                       input logic [31:0] smp);
    in_word_t w;
    w.action = act;
    w.band_addr = band[4:0];
    w.bin_index = bin[8:0];
    w.weight = wt[15:0];
    w.range_first = lo[8:0];
    w.range_last = hi[8:0];
    w.sample = smp;
    return w;
  endfunction

  function automatic logic [31:0] rnd_sample();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF;
      1: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Load random bounds for the bands in use and every weight inside them, so no
  // sample ever adds an unwritten entry.
  task automatic load_bank(input int nb, input int nbands, input bit narrow);
    int lo;
    int hi;
    for (int b = 0; b < nbands; b++) begin
      lo = $urandom_range(nb - 1);
      hi = narrow ? lo + $urandom_range(2) : $urandom_range(nb - 1);
      if ($urandom_range(9) == 0) hi = lo - 1; // empty band unless lo is 0
      if (hi > NBINS - 1) hi = NBINS - 1;
      if (hi < 0) hi = 0;
      send_word(mk_word(ACT_BOUNDS, b, $urandom, $urandom, lo, hi, $urandom));
      for (int k = lo; k <= hi; k++)
        if (k < NBINS)
          send_word(mk_word(ACT_WEIGHT, b, k, $urandom_range(3) == 0 ? 16'hFFFF : $urandom,
                            $urandom, $urandom, $urandom));
    end
  endtask

  // A frame of samples; only bins whose weights are loaded in every band they hit.
  task automatic send_frame(input int nb);
    for (int k = 0; k < nb; k++) begin
      if ($urandom_range(15) == 0)
        send_word(mk_word(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
      send_word(mk_word(ACT_SAMPLE, $urandom, k, $urandom, $urandom, $urandom,
                        rnd_sample()));
      if ($urandom_range(20) == 0)
        send_word(mk_word(ACT_SAMPLE, $urandom, k, $urandom, $urandom, $urandom,
                          rnd_sample())); // repeated bin
    end
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        word_cnt++;
        if (band_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word band %0d", out_data.band));
        end else begin
          if (out_data.band !== band_q[0].band)
            report_mismatch($sformatf("band %0d, want %0d", out_data.band, band_q[0].band));
          if (out_data.band_value !== band_q[0].band_value)
            report_mismatch($sformatf("band %0d value %0h, want %0h", band_q[0].band,
                                      out_data.band_value, band_q[0].band_value));
          if (out_data.last !== band_q[0].last)
            report_mismatch($sformatf("band %0d last %b", band_q[0].band, out_data.last));
          void'(band_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired with %0d words pending", band_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed: extremes, register clamps, ignored words, large sums, cube root.
  task automatic test_directed();
    write_reg(CFG_NUM_BINS, 10'd4);
    write_reg(CFG_BANDS, 6'd32);
    for (int b = 0; b < NBANDS; b++)
      send_word(mk_word(ACT_BOUNDS, b, 0, 0, (b == 1) ? 3 : 0, (b == 1) ? 1 : 3, 0));
    for (int k = 0; k < 4; k++) begin
      send_word(mk_word(ACT_WEIGHT, 0, k, 16'hFFFF, 0, 0, 0));
      for (int b = 1; b < NBANDS; b++) send_word(mk_word(ACT_WEIGHT, b, k, b, 0, 0, 0));
    end
    send_word(mk_word(ACT_NONE, 31, 511, 16'hFFFF, 511, 511, 32'hFFFF_FFFF));
    send_word(mk_word(ACT_SAMPLE, 0, 511, 0, 0, 0, 32'hFFFF_FFFF)); // beyond bins in use
    for (int r = 0; r < 3; r++) // repeats build a large sum in band 0
      for (int k = 0; k < 3; k++) send_word(mk_word(ACT_SAMPLE, 0, k, 0, 0, 0, '1));
    send_word(mk_word(ACT_SAMPLE, 0, 3, 0, 0, 0, 32'hFFFF_FFFF));
    write_reg(CFG_COMPRESS, 10'd1);
    for (int k = 0; k < 4; k++) send_word(mk_word(ACT_SAMPLE, 0, k, 0, 0, 0, '1));
    write_reg(CFG_COMPRESS, 10'd0);
    // Register clamps: zero acts as one, oversized as the maximum.
    write_reg(CFG_NUM_BINS, 10'd0);
    write_reg(CFG_BANDS, 6'd0);
    send_word(mk_word(ACT_SAMPLE, 0, 0, 0, 0, 0, 32'd1));
    write_reg(CFG_BANDS, 6'd63);
    send_word(mk_word(ACT_SAMPLE, 0, 0, 0, 0, 0, 32'd0));
  endtask

  // Random frames over a setting of the registers.
  task automatic test_random_frames(input int nb, input int nbands, input bit cmp,
                                    input int frames);
    write_reg(CFG_NUM_BINS, nb[9:0]);
    write_reg(CFG_BANDS, nbands[5:0]);
    write_reg(CFG_COMPRESS, {9'd0, cmp});
    load_bank(nb, nbands, nb > 16);
    for (int f = 0; f < frames; f++) begin
      send_frame(nb);
      if (f == 0) wait_drained(); // sender holds off until all bands are back
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    err_cnt = 0;
    word_cnt = 0;
    frame_cnt = 0;
    wdog = 0;
    bins_reg = 10'd256;
    bands_reg = 6'd23;
    cbrt_on = 1'b0;
    for (int b = 0; b < NBANDS; b++) begin
      band_sum[b] = '0;
      lo_bin[b] = '0;
      hi_bin[b] = '0;
      for (int k = 0; k < NBINS; k++) begin
        wt_mem[b][k] = '0;
      end
    end
    snd_idle_pct = 17;
    rcv_idle_pct = 88;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_frames(6, 32, 1'b0, 3);
    snd_idle_pct = 88;
    rcv_idle_pct = 17;
    test_random_frames(5, 7, 1'b1, 6);
    test_random_frames(1, 1, 1'b0, 12);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_frames(4, 12, 1'b1, 4);

    wait_drained();
    $display("covered %0d frames, %0d band words checked, %0d mismatches",
             frame_cnt, word_cnt, err_cnt);
    $display("register clamps, ignored words, large sums and cube root exercised");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fbe_pkg.sv
rtl/fbe_ram.sv
rtl/fbe_cell.sv
rtl/fbe_cbrt.sv
rtl/filter_bank_band_energy.sv
bench/tb_filter_bank_band_energy.sv
